// ===== hdl/btbf_pkg.sv =====
// shared types and constants of the boundary tag best fit allocator
`default_nettype none

package btbf_pkg;

    localparam int LIM_W     = 17;
    localparam int TAG_BYTES = 16;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 17'h10000;

    localparam logic [1:0] KIND_FREE = 2'd1;
    localparam logic [1:0] KIND_USED = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_LIST_FULL = 2'd2;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_LIMIT = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] alloc_bytes;
        logic [31:0] free_address;
    } t_req;

    typedef struct packed {
        logic [31:0] block_address;
        logic [1:0]  status;
    } t_rsp;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE,
        S_FIT, S_GROW, S_GCHK, S_GPREV,
        S_FRD, S_FHEAD, S_FFOOT, S_FPREV, S_FNEXT,
        S_RCH, S_RCF, S_RCP, S_RCN, S_RPH, S_RPF, S_RRP, S_RRN, S_INS,
        S_TAKE, S_AH, S_AF, S_UH, S_UF,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MODE_GROW, MODE_FREE, MODE_SPLIT
    } t_mode;

    typedef enum logic [1:0] {
        LOP_NONE, LOP_REMOVE, LOP_INSERT
    } t_list_op;

endpackage

`default_nettype wire

// ===== hdl/btbf_tag_mem.sv =====
// boundary tag memory, one write port and one registered read port
`default_nettype none

module btbf_tag_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14,
    parameter int DW    = 19
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/btbf_flist.sv =====
// size sorted free list with shift insert and remove
`default_nettype none

module btbf_flist
    import btbf_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int IW        = 4,
    parameter int CNTW      = 5,
    parameter int AW        = 14,
    parameter int SZ_W      = 17,
    parameter int INIT_SIZE = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_list_op        i_op,
    input  logic [IW-1:0]   i_pos,
    input  logic [AW-1:0]   i_word,
    input  logic [SZ_W-1:0] i_size,
    input  logic [IW-1:0]   i_rd_idx,
    output logic [AW-1:0]   o_rd_word,
    output logic [SZ_W-1:0] o_rd_size,
    output logic [CNTW-1:0] o_count
);

    logic [AW-1:0]   r_word [SLOTS];
    logic [SZ_W-1:0] r_size [SLOTS];
    logic [CNTW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SLOTS; j++) begin
                r_word[j] <= '0;
                r_size[j] <= '0;
            end
            r_size[0] <= SZ_W'(INIT_SIZE);
            r_count   <= CNTW'(1);
        end else begin
            case (i_op)
                LOP_REMOVE: begin
                    for (int j = 0; j < SLOTS - 1; j++) begin
                        if (IW'(j) >= i_pos) begin
                            r_word[j] <= r_word[j+1];
                            r_size[j] <= r_size[j+1];
                        end
                    end
                    r_count <= r_count - CNTW'(1);
                end
                LOP_INSERT: begin
                    for (int j = 1; j < SLOTS; j++) begin
                        if (IW'(j) > i_pos) begin
                            r_word[j] <= r_word[j-1];
                            r_size[j] <= r_size[j-1];
                        end
                    end
                    r_word[i_pos] <= i_word;
                    r_size[i_pos] <= i_size;
                    r_count       <= r_count + CNTW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_rd_word = r_word[i_rd_idx];
    assign o_rd_size = r_size[i_rd_idx];
    assign o_count   = r_count;

endmodule

`default_nettype wire

// ===== hdl/boundary_tag_best_fit_allocator_core.sv =====
// Best fit heap allocator with boundary tags held in a tag memory with a registered
// read port and a size sorted free list of FREE_SLOTS entries, one request at a time.
// The free list is walked one entry per cycle. An allocate scans the list and, when the
// block is split, walks it again to insert the rest; a heap growth adds a release.
// A free takes up to three list walks. After reset the tag memory is initialized,
// with the input stalled; configuration writes are taken throughout.
`default_nettype none

module boundary_tag_best_fit_allocator_core
    import btbf_pkg::*;
#(
    parameter int HEAP_WORDS = 16384,
    parameter int FREE_SLOTS = 16,
    parameter int PAGE_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_req        i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_rsp        o_out_word,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);

    localparam int CAP       = HEAP_WORDS * 4;
    localparam int AW        = $clog2(HEAP_WORDS);
    localparam int SZ_W      = $clog2(CAP + 1);
    localparam int CW        = ((SZ_W > LIM_W) ? SZ_W : LIM_W) + 1;
    localparam int TAG_W     = SZ_W + 2;
    localparam int INIT_HEAP = (PAGE_BYTES < CAP) ? PAGE_BYTES : CAP;
    localparam int INIT_FOOT = (INIT_HEAP - 8) / 4;
    localparam int IW        = $clog2(FREE_SLOTS);
    localparam int CNTW      = $clog2(FREE_SLOTS + 1);

    function automatic logic [AW-1:0] f_word(input logic [SZ_W-1:0] a);
        f_word = a[AW+1:2];
    endfunction

    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr, n_clr;
    logic [31:0]     r_base;
    logic [LIM_W-1:0] r_limit;
    logic [SZ_W-1:0] r_heap, n_heap;
    t_mode           r_mode, n_mode;
    logic [CW-1:0]   r_need, n_need;
    logic [CNTW-1:0] r_i, n_i;
    logic [IW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_w, n_w;
    logic [SZ_W-1:0] r_sz, n_sz;
    logic [SZ_W-1:0] r_off, n_off;
    logic [SZ_W-1:0] r_s, n_s;
    logic [SZ_W-1:0] r_ps, n_ps;
    logic [SZ_W-1:0] r_ns, n_ns;
    logic [SZ_W-1:0] r_start, n_start;
    logic [SZ_W-1:0] r_total, n_total;
    logic [TAG_W-1:0] r_tag, n_tag;
    logic            r_hp, n_hp;
    logic            r_hn, n_hn;
    logic            r_refit, n_refit;
    logic [CW-1:0]   r_grow, n_grow;
    logic [AW-1:0]   r_ins_w, n_ins_w;
    logic [SZ_W-1:0] r_ins_s, n_ins_s;
    logic [1:0]      r_status, n_status;
    logic [31:0]     r_addr, n_addr;
    logic            r_ov, n_ov;
    t_rsp            r_out, n_out;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [TAG_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [TAG_W-1:0] mem_rdata;

    t_list_op         lop;
    logic [IW-1:0]    lop_pos;
    logic [AW-1:0]    ls_word;
    logic [SZ_W-1:0]  ls_size;
    logic [CNTW-1:0]  ls_count;

    logic [1:0]      rd_kind;
    logic [SZ_W-1:0] rd_size;
    logic            walk_end, list_full, fit_hit, ins_hit;
    logic [CW-1:0]   need_in, alloc_ext;
    logic [31:0]     free_off32;
    logic            free_ok;
    logic [SZ_W-1:0] off_s, aoff, need_sz;
    logic            head_ok, prev_ok, next_ok;
    logic [CW-1:0]   grow_sum, lim_c, rem;

    btbf_tag_mem #(
        .DEPTH (HEAP_WORDS),
        .AW    (AW),
        .DW    (TAG_W)
    ) u_tag_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    btbf_flist #(
        .SLOTS     (FREE_SLOTS),
        .IW        (IW),
        .CNTW      (CNTW),
        .AW        (AW),
        .SZ_W      (SZ_W),
        .INIT_SIZE (INIT_HEAP)
    ) u_flist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (lop),
        .i_pos     (lop_pos),
        .i_word    (r_ins_w),
        .i_size    (r_ins_s),
        .i_rd_idx  (r_i[IW-1:0]),
        .o_rd_word (ls_word),
        .o_rd_size (ls_size),
        .o_count   (ls_count)
    );

    assign rd_kind    = mem_rdata[TAG_W-1 -: 2];
    assign rd_size    = mem_rdata[SZ_W-1:0];
    assign walk_end   = (r_i == ls_count);
    assign list_full  = (ls_count == CNTW'(FREE_SLOTS));
    assign fit_hit    = (CW'(ls_size) >= r_need);
    assign ins_hit    = (ls_size > r_ins_s);
    assign alloc_ext  = CW'(i_in_word.alloc_bytes) + CW'(3);
    assign need_in    = (alloc_ext & ~CW'(3)) + CW'(TAG_BYTES);
    assign free_off32 = i_in_word.free_address - r_base - 32'd8;
    assign free_ok    = (free_off32[1:0] == 2'b00) && (free_off32 < 32'(r_heap));
    assign off_s      = r_off + r_s;
    assign aoff       = SZ_W'({r_w, 2'b00});
    assign need_sz    = r_need[SZ_W-1:0];
    assign head_ok    = (rd_kind == KIND_USED) && (rd_size >= SZ_W'(TAG_BYTES))
                     && (rd_size[1:0] == 2'b00) && (rd_size <= r_heap - r_off);
    assign prev_ok    = (r_off >= SZ_W'(TAG_BYTES)) && (rd_kind == KIND_FREE)
                     && (rd_size <= r_off) && (rd_size >= SZ_W'(TAG_BYTES));
    assign next_ok    = (off_s < r_heap) && (rd_kind == KIND_FREE)
                     && (rd_size >= SZ_W'(TAG_BYTES)) && (rd_size <= r_heap - off_s);
    assign grow_sum   = CW'(r_heap) + r_grow;
    assign lim_c      = (CW'(r_limit) < CW'(CAP)) ? CW'(r_limit) : CW'(CAP);
    assign rem        = CW'(r_sz) - r_need;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(HEAP_WORDS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_word.req_type == REQ_ALLOC) n_state = S_FIT;
                    else if (free_ok) n_state = S_FRD;
                    else n_state = S_DONE;
                end
            end
            S_FIT: begin
                if (walk_end) n_state = r_refit ? S_DONE : S_GROW;
                else if (fit_hit) n_state = S_TAKE;
            end
            S_GROW: begin
                if (r_grow >= r_need) n_state = S_GCHK;
            end
            S_GCHK: begin
                n_state = (grow_sum > lim_c) ? S_DONE : S_GPREV;
            end
            S_GPREV: begin
                n_state = (!prev_ok && list_full) ? S_DONE : S_RCH;
            end
            S_FRD:   n_state = S_FHEAD;
            S_FHEAD: n_state = head_ok ? S_FFOOT : S_DONE;
            S_FFOOT: n_state = (mem_rdata == r_tag) ? S_FPREV : S_DONE;
            S_FPREV: n_state = S_FNEXT;
            S_FNEXT: begin
                n_state = (!r_hp && !next_ok && list_full) ? S_DONE : S_RCH;
            end
            S_RCH: n_state = S_RCF;
            S_RCF: n_state = S_RCP;
            S_RCP: n_state = S_RCN;
            S_RCN: n_state = S_RPH;
            S_RPH: n_state = S_RPF;
            S_RPF: n_state = S_RRP;
            S_RRP: begin
                if (!r_hp || walk_end || ls_word == f_word(r_start)) n_state = S_RRN;
            end
            S_RRN: begin
                if (!r_hn || walk_end || ls_word == f_word(off_s)) n_state = S_INS;
            end
            S_INS: begin
                if (list_full || walk_end || ins_hit) begin
                    case (r_mode)
                        MODE_GROW:  n_state = S_FIT;
                        MODE_SPLIT: n_state = S_UH;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_TAKE: n_state = (rem < CW'(TAG_BYTES)) ? S_UH : S_AH;
            S_AH:   n_state = S_AF;
            S_AF:   n_state = S_INS;
            S_UH:   n_state = S_UF;
            S_UF:   n_state = S_DONE;
            S_DONE: begin
                if (!r_ov || !i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs and datapath
    always_comb begin
        n_clr    = r_clr;
        n_heap   = r_heap;
        n_mode   = r_mode;
        n_need   = r_need;
        n_i      = r_i;
        n_idx    = r_idx;
        n_w      = r_w;
        n_sz     = r_sz;
        n_off    = r_off;
        n_s      = r_s;
        n_ps     = r_ps;
        n_ns     = r_ns;
        n_start  = r_start;
        n_total  = r_total;
        n_tag    = r_tag;
        n_hp     = r_hp;
        n_hn     = r_hn;
        n_refit  = r_refit;
        n_grow   = r_grow;
        n_ins_w  = r_ins_w;
        n_ins_s  = r_ins_s;
        n_status = r_status;
        n_addr   = r_addr;
        n_ov     = r_ov && i_out_stall;
        n_out    = r_out;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;
        lop       = LOP_NONE;
        lop_pos   = r_i[IW-1:0];
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                if (r_clr == '0 || r_clr == AW'(INIT_FOOT)) begin
                    mem_wdata = {KIND_FREE, SZ_W'(INIT_HEAP)};
                end
                n_clr = r_clr + AW'(1);
            end
            S_IDLE: begin
                n_status = ST_OK;
                n_addr   = '0;
                n_need   = need_in;
                n_i      = '0;
                n_refit  = 1'b0;
                n_off    = free_off32[SZ_W-1:0];
            end
            S_FIT: begin
                if (walk_end) begin
                    if (r_refit) n_status = ST_NO_SPACE;
                    else n_grow = '0;
                end else if (fit_hit) begin
                    n_idx = r_i[IW-1:0];
                    n_w   = ls_word;
                    n_sz  = ls_size;
                end else begin
                    n_i = r_i + CNTW'(1);
                end
            end
            S_GROW: begin
                if (r_grow < r_need) n_grow = r_grow + CW'(PAGE_BYTES);
            end
            S_GCHK: begin
                if (grow_sum > lim_c) begin
                    n_status = ST_NO_SPACE;
                end else begin
                    mem_raddr = f_word(r_heap - SZ_W'(8));
                    n_off     = r_heap;
                end
            end
            S_GPREV: begin
                n_hp = prev_ok;
                n_ps = rd_size;
                n_hn = 1'b0;
                if (!prev_ok && list_full) begin
                    n_status = ST_LIST_FULL;
                end else begin
                    n_s     = r_grow[SZ_W-1:0];
                    n_heap  = grow_sum[SZ_W-1:0];
                    n_mode  = MODE_GROW;
                    n_refit = 1'b1;
                end
            end
            S_FRD: begin
                mem_raddr = f_word(r_off);
            end
            S_FHEAD: begin
                n_tag     = mem_rdata;
                n_s       = rd_size;
                mem_raddr = f_word(r_off + rd_size - SZ_W'(8));
            end
            S_FFOOT: begin
                mem_raddr = f_word(r_off - SZ_W'(8));
            end
            S_FPREV: begin
                n_hp      = prev_ok;
                n_ps      = rd_size;
                mem_raddr = f_word(off_s);
            end
            S_FNEXT: begin
                n_hn   = next_ok;
                n_ns   = rd_size;
                n_mode = MODE_FREE;
                if (!r_hp && !next_ok && list_full) n_status = ST_LIST_FULL;
            end
            S_RCH: begin
                mem_we    = 1'b1;
                mem_waddr = f_word(r_off);
                n_start   = r_hp ? (r_off - r_ps) : r_off;
                n_total   = r_s + (r_hp ? r_ps : '0) + (r_hn ? r_ns : '0);
            end
            S_RCF: begin
                mem_we    = 1'b1;
                mem_waddr = f_word(off_s - SZ_W'(8));
            end
            S_RCP: begin
                mem_we    = r_hp;
                mem_waddr = f_word(r_off - SZ_W'(8));
            end
            S_RCN: begin
                mem_we    = r_hn;
                mem_waddr = f_word(off_s);
            end
            S_RPH: begin
                mem_we    = 1'b1;
                mem_waddr = f_word(r_start);
                mem_wdata = {KIND_FREE, r_total};
            end
            S_RPF: begin
                mem_we    = 1'b1;
                mem_waddr = f_word(r_start + r_total - SZ_W'(8));
                mem_wdata = {KIND_FREE, r_total};
                n_i       = '0;
            end
            S_RRP: begin
                if (!r_hp || walk_end) begin
                    n_i = '0;
                end else if (ls_word == f_word(r_start)) begin
                    lop = LOP_REMOVE;
                    n_i = '0;
                end else begin
                    n_i = r_i + CNTW'(1);
                end
            end
            S_RRN: begin
                if (!r_hn || walk_end || ls_word == f_word(off_s)) begin
                    if (r_hn && !walk_end) lop = LOP_REMOVE;
                    n_i     = '0;
                    n_ins_w = f_word(r_start);
                    n_ins_s = r_total;
                end else begin
                    n_i = r_i + CNTW'(1);
                end
            end
            S_INS: begin
                if (list_full) begin
                    n_i = '0;
                end else if (walk_end || ins_hit) begin
                    lop = LOP_INSERT;
                    n_i = '0;
                end else begin
                    n_i = r_i + CNTW'(1);
                end
            end
            S_TAKE: begin
                lop     = LOP_REMOVE;
                lop_pos = r_idx;
                if (rem < CW'(TAG_BYTES)) begin
                    n_need = CW'(r_sz);
                end else begin
                    n_ins_w = f_word(aoff + need_sz);
                    n_ins_s = rem[SZ_W-1:0];
                    n_mode  = MODE_SPLIT;
                end
            end
            S_AH: begin
                mem_we    = 1'b1;
                mem_waddr = f_word(aoff + need_sz);
                mem_wdata = {KIND_FREE, rem[SZ_W-1:0]};
            end
            S_AF: begin
                mem_we    = 1'b1;
                mem_waddr = f_word(aoff + r_sz - SZ_W'(8));
                mem_wdata = {KIND_FREE, rem[SZ_W-1:0]};
                n_i       = '0;
            end
            S_UH: begin
                mem_we    = 1'b1;
                mem_waddr = r_w;
                mem_wdata = {KIND_USED, need_sz};
            end
            S_UF: begin
                mem_we    = 1'b1;
                mem_waddr = f_word(aoff + need_sz - SZ_W'(8));
                mem_wdata = {KIND_USED, need_sz};
                n_addr    = r_base + 32'(aoff) + 32'd8;
            end
            S_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    n_out.block_address = r_addr;
                    n_out.status        = r_status;
                    n_ov                = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_heap  <= SZ_W'(INIT_HEAP);
            r_ov    <= 1'b0;
            r_base  <= '0;
            r_limit <= LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_heap  <= n_heap;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HEAP_BASE:  r_base  <= i_cfg_wdata;
                    CFG_HEAP_LIMIT: r_limit <= i_cfg_wdata[LIM_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_need   <= n_need;
        r_i      <= n_i;
        r_idx    <= n_idx;
        r_w      <= n_w;
        r_sz     <= n_sz;
        r_off    <= n_off;
        r_s      <= n_s;
        r_ps     <= n_ps;
        r_ns     <= n_ns;
        r_start  <= n_start;
        r_total  <= n_total;
        r_tag    <= n_tag;
        r_hp     <= n_hp;
        r_hn     <= n_hn;
        r_refit  <= n_refit;
        r_grow   <= n_grow;
        r_ins_w  <= n_ins_w;
        r_ins_s  <= n_ins_s;
        r_status <= n_status;
        r_addr   <= n_addr;
        r_out    <= n_out;
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

// ===== hdl/btbf_checker.sv =====
// port level checks of the allocator core, bound to the top level
`default_nettype none

module btbf_prop_checker
    import btbf_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire t_rsp o_out_word
);

    // held result word stays put while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.status == ST_OK || o_out_word.status == ST_NO_SPACE
                         || o_out_word.status == ST_LIST_FULL))
        else $error("bad status code");

    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != ST_OK |-> o_out_word.block_address == 32'd0)
        else $error("failed request with nonzero address");

    // tag memory init keeps the input stalled after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("not idle-stalled after reset");

endmodule

bind boundary_tag_best_fit_allocator_core btbf_prop_checker u_btbf_prop_checker (.*);

`default_nettype wire

// ===== bench/btbf_checker.sv =====
// checker for the allocator: follows both channels, predicts each response word and compares
`timescale 1ns / 100ps
`default_nettype none

module btbf_checker
    import btbf_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  t_req        i_in_word,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  t_rsp        i_out_word,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire  [31:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int WORDS = 16384;
    localparam int SLOTS = 16;
    localparam int PAGE  = 4096;

    logic [31:0] tags [WORDS];
    logic [31:0] slots [SLOTS];
    logic [31:0] n_free;
    logic [31:0] heap_size;
    logic [31:0] base_addr;
    logic [31:0] limit_bytes;
    t_rsp        rsp_queue [$];

    function automatic logic [31:0] tag_get(input logic [31:0] w);
        return (w < WORDS) ? tags[w] : 32'd0;
    endfunction

    function automatic void tag_set(input logic [31:0] w, input logic [31:0] v);
        if (w < WORDS) tags[w] = v;
    endfunction

    function automatic logic [1:0] kind_f(input logic [31:0] t);
        return t[31:30];
    endfunction

    function automatic logic [31:0] size_f(input logic [31:0] t);
        return {2'b00, t[29:0]};
    endfunction

    function automatic void write_block(input logic [31:0] off, input logic [31:0] sz,
                                        input logic [1:0] k);
        logic [31:0] t;
        t = {k, sz[29:0]};
        tag_set(off >> 2, t);
        tag_set((off + sz - 8) >> 2, t);
    endfunction

    function automatic void drop_at(input logic [31:0] i);
        if (i >= n_free) return;
        for (int j = i; j + 1 < n_free; j++) slots[j] = slots[j + 1];
        n_free--;
    endfunction

    function automatic void drop_word(input logic [31:0] w);
        for (int i = 0; i < n_free; i++)
            if (slots[i] == w) begin
                drop_at(i);
                return;
            end
    endfunction

    function automatic void add_sorted(input logic [31:0] w);
        logic [31:0] s;
        int          pos;
        s = size_f(tag_get(w));
        pos = 0;
        if (n_free >= SLOTS) return;
        while (pos < n_free && size_f(tag_get(slots[pos])) <= s) pos++;
        for (int i = n_free; i > pos; i--) slots[i] = slots[i - 1];
        slots[pos] = w;
        n_free++;
    endfunction

    function automatic bit left_free(input logic [31:0] off, output logic [31:0] ps);
        logic [31:0] t;
        ps = 0;
        if (off < TAG_BYTES) return 0;
        t = tag_get((off - 8) >> 2);
        if (kind_f(t) != KIND_FREE || size_f(t) > off || size_f(t) < TAG_BYTES) return 0;
        ps = size_f(t);
        return 1;
    endfunction

    function automatic bit right_free(input logic [31:0] off, input logic [31:0] s,
                                      output logic [31:0] ns);
        logic [31:0] nx, t;
        ns = 0;
        nx = off + s;
        if (nx >= heap_size) return 0;
        t = tag_get(nx >> 2);
        if (kind_f(t) != KIND_FREE || size_f(t) < TAG_BYTES || size_f(t) > heap_size - nx)
            return 0;
        ns = size_f(t);
        return 1;
    endfunction

    function automatic void merge_free(input logic [31:0] off, input logic [31:0] s);
        logic [31:0] start, total, ps, ns;
        bit          hp, hn;
        start = off;
        total = s;
        hp = left_free(off, ps);
        hn = right_free(off, s, ns);
        tag_set(off >> 2, 0);
        tag_set((off + s - 8) >> 2, 0);
        if (hp) begin
            start = off - ps;
            drop_word(start >> 2);
            tag_set((off - 8) >> 2, 0);
            total += ps;
        end
        if (hn) begin
            drop_word((off + s) >> 2);
            tag_set((off + s) >> 2, 0);
            total += ns;
        end
        write_block(start, total, KIND_FREE);
        add_sorted(start >> 2);
    endfunction

    function automatic int best_fit(input logic [31:0] need);
        for (int i = 0; i < n_free; i++)
            if (size_f(tag_get(slots[i])) >= need) return i;
        return -1;
    endfunction

    function automatic t_rsp serve_request(input t_req rq);
        t_rsp        r;
        logic [31:0] need, grow, old, ps, ns, w, off, sz, t, s;
        int          idx;
        r = '0;
        if (rq.req_type == REQ_ALLOC) begin
            need = ((32'(rq.alloc_bytes) + 3) & ~32'd3) + TAG_BYTES;
            idx = best_fit(need);
            if (idx < 0) begin
                grow = ((need + PAGE - 1) / PAGE) * PAGE;
                old = heap_size;
                if (old + grow > ((limit_bytes < WORDS * 4) ? limit_bytes : WORDS * 4))
                    r.status = ST_NO_SPACE;
                else if (!left_free(old, ps) && n_free >= SLOTS)
                    r.status = ST_LIST_FULL;
                else begin
                    heap_size = old + grow;
                    merge_free(old, grow);
                    idx = best_fit(need);
                    if (idx < 0) r.status = ST_NO_SPACE;
                end
            end
            if (r.status == ST_OK && idx >= 0) begin
                w = slots[idx];
                off = w << 2;
                sz = size_f(tag_get(w));
                drop_at(idx);
                if (sz - need < TAG_BYTES) need = sz;
                else begin
                    write_block(off + need, sz - need, KIND_FREE);
                    add_sorted((off + need) >> 2);
                end
                write_block(off, need, KIND_USED);
                r.block_address = base_addr + off + 8;
            end
        end else begin
            off = rq.free_address - base_addr - 8;
            if (off[1:0] == 0 && off < heap_size) begin
                t = tag_get(off >> 2);
                s = size_f(t);
                if (kind_f(t) == KIND_USED && s >= TAG_BYTES && s[1:0] == 0 &&
                    s <= heap_size - off && tag_get((off + s - 8) >> 2) == t) begin
                    if (!left_free(off, ps) && !right_free(off, s, ns) && n_free >= SLOTS)
                        r.status = ST_LIST_FULL;
                    else
                        merge_free(off, s);
                end
            end
        end
        return r;
    endfunction

    assign o_pending = rsp_queue.size();

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            for (int i = 0; i < WORDS; i++) tags[i] = 0;
            heap_size = PAGE;
            write_block(0, PAGE, KIND_FREE);
            for (int i = 0; i < SLOTS; i++) slots[i] = 0;
            n_free = 1;
            base_addr = 0;
            limit_bytes = 32'(LIMIT_RESET);
            rsp_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_HEAP_BASE) base_addr = i_cfg_wdata;
                else limit_bytes = {15'd0, i_cfg_wdata[16:0]};
            end
            if (i_in_valid && !i_in_stall) rsp_queue.push_back(serve_request(i_in_word));
            if (i_out_valid && !i_out_stall) begin
                if (rsp_queue.size() == 0) begin
                    $error("unexpected word: block_address %h status %0d",
                           i_out_word.block_address, i_out_word.status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_rsp = rsp_queue.pop_front();
                    if (exp_rsp !== i_out_word) begin
                        if (exp_rsp.block_address !== i_out_word.block_address)
                            $error("block_address: expected %h actual %h",
                                   exp_rsp.block_address, i_out_word.block_address);
                        if (exp_rsp.status !== i_out_word.status)
                            $error("status: expected %0d actual %0d",
                                   exp_rsp.status, i_out_word.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// top of the allocator testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import btbf_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_req        in_word;
    logic        out_valid;
    logic        out_stall;
    t_rsp        out_word;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;
    int          fail_count;
    int          pending;
    logic [31:0] live_addrs [$];
    logic [31:0] cur_base;
    int          burst_left;

    boundary_tag_best_fit_allocator_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_word(out_word),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata)
    );

    btbf_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_word(out_word),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver stall pattern, drawn anew in each cycle, with calm cycles mixed in
    always @(negedge clk) begin
        int mode;
        mode = ($urandom_range(0, 199) < 40) ? 0 : 1;
        if (!rst_n) out_stall <= 1'b0;
        else out_stall <= mode ? ($urandom_range(0, 3) == 0) : 1'b0;
    end

    initial begin
        #60_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic send_word(input t_req w);
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic req_alloc(input logic [15:0] n);
        t_req w;
        w = '0;
        w.req_type = REQ_ALLOC;
        w.alloc_bytes = n;
        w.free_address = $urandom;
        send_word(w);
    endtask

    task automatic req_free(input logic [31:0] a);
        t_req w;
        w = '0;
        w.req_type = ~REQ_ALLOC;
        w.alloc_bytes = $urandom;
        w.free_address = a;
        send_word(w);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] v);
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // returned addresses are learned by watching the response words
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall && out_word.status == ST_OK &&
            out_word.block_address != 0)
            live_addrs.push_back(out_word.block_address);
    end

    task automatic free_some;
        int k;
        logic [31:0] a;
        k = $urandom_range(0, live_addrs.size() - 1);
        a = live_addrs[k];
        live_addrs.delete(k);
        req_free(a);
    endtask

    task automatic run_phase(input int count);
        int c;
        for (int i = 0; i < count; i++) begin
            c = $urandom_range(0, 99);
            if (c < 45) req_alloc((c < 5) ? 16'($urandom) : 16'($urandom_range(0, 600)));
            else if (c < 90 && live_addrs.size() > 0) free_some();
            else if (c < 95) req_free($urandom);
            else req_free(cur_base + 8 + 4 * $urandom_range(0, 1100));
        end
    endtask

    initial begin
        in_valid   = 1'b0;
        in_word    = '0;
        out_stall  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_HEAP_BASE;
        cfg_wdata  = '0;
        burst_left = 0;
        cur_base   = 0;
        rst_n      = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed part
        req_alloc(16'd0);
        req_alloc(16'd1);
        req_alloc(16'd4080);
        req_alloc(16'd65535);
        req_alloc(16'd6000);
        req_free(32'hFFFF_FFFF);
        req_free(32'd9);
        req_free(32'd8);
        req_free(32'd8);
        for (int i = 0; i < 16; i++) req_alloc(16'd20);
        while (pending != 0) @(negedge clk);
        repeat (5) @(negedge clk);
        for (int i = 0; i < live_addrs.size(); i += 2) req_free(live_addrs[i]);

        run_phase(350);
        write_reg(CFG_HEAP_LIMIT, 32'd4096);
        write_reg(CFG_HEAP_BASE, 32'hFFFF_FFF2);
        while (pending != 0) @(negedge clk);
        live_addrs.delete();
        cur_base = 32'hFFFF_FFF2;
        req_free(32'hFFFF_FFFA);
        run_phase(250);
        write_reg(CFG_HEAP_LIMIT, 32'h1_FFFF);
        write_reg(CFG_HEAP_BASE, 32'h8000_0000);
        live_addrs.delete();
        cur_base = 32'h8000_0000;
        run_phase(300);
        write_reg(CFG_HEAP_LIMIT, 32'd12288);
        write_reg(CFG_HEAP_BASE, 32'd0);
        live_addrs.delete();
        cur_base = 0;
        run_phase(230);

        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
